[design/bae_pkg.sv]
// Shared types and constants for the binary arithmetic encoder.
// No dependencies; used by bae_ctrl, bae_datapath and binary_arithmetic_encoder.
package bae_pkg;

    localparam int unsigned CODE_W    = 32;
    localparam int unsigned PROB_W    = 12;
    localparam int unsigned PROD_W    = CODE_W + PROB_W;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

    localparam logic [CODE_W-1:0] ALL_ONES  = {CODE_W{1'b1}};
    localparam logic [BYTE_W-1:0] BYTE_FILL = {BYTE_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BYTES);
    localparam logic [CNT_W-1:0]  CNT_FINAL = CNT_W'(MAX_BYTES - 1);

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture an input transaction
        logic multiply;  // register span * prob
        logic update;    // move one bound to the split point
        logic shift;     // drop the top byte just delivered
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_flush;
        logic emit_avail;  // a settled byte is waiting
        logic last;        // that byte ends the transaction's output
    } dp_status_t;

endpackage

[design/binary_arithmetic_encoder.sv]
// Top level of the 32-bit carryless binary arithmetic encoder.
// Depends on bae_pkg, bae_ctrl and bae_datapath.
//
// Input channel (s_valid/s_ready): one transaction is an encode (s_command = 0,
// with s_bit_value and s_prob) or a flush (s_command = 1). Output channel
// (m_valid/m_ready) carries code bytes in m_out_byte; m_last marks the final
// byte caused by one input transaction. An encode gives zero to four bytes,
// a flush always four (low bound, most significant first).
//
// Sequence: an encode is captured, then the span * prob product is
// registered, then one bound is updated, then the settled bytes go out at
// one byte per cycle while the receiver keeps m_ready high. An encode that
// settles no byte still passes through the byte loop to find none before it
// returns to idle. A flush skips the multiply and update and goes straight
// to the byte loop. With a single product register, one transaction is in
// flight at a time.
//
// Reset (aresetn low, synchronous) returns the bounds to 0 and all ones and
// the controller to idle; s_ready stays low while reset is applied. When the
// receiver stalls, hold the current byte and m_last on the output and take no
// new input until the bytes drain.
module binary_arithmetic_encoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic                       s_bit_value,
    input  logic [bae_pkg::PROB_W-1:0] s_prob,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bae_pkg::BYTE_W-1:0] m_out_byte,
    output logic                       m_last
);
    import bae_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence: capture, multiply, update, then deliver settled bytes
    bae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Bounds, product register and byte shifter
    bae_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_command   (s_command),
        .in_bit_value (s_bit_value),
        .in_prob      (s_prob),
        .status       (status),
        .out_byte     (m_out_byte)
    );

    assign m_last = status.last;

endmodule

[design/bae_datapath.sv]
// Datapath of the binary arithmetic encoder: bounds, split multiply, byte shifter.
// Depends on bae_pkg; driven by bae_ctrl through dp_cmd_t.
module bae_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bae_pkg::dp_cmd_t           cmd,
    input  logic                       in_command,
    input  logic                       in_bit_value,
    input  logic [bae_pkg::PROB_W-1:0] in_prob,
    output bae_pkg::dp_status_t        status,
    output logic [bae_pkg::BYTE_W-1:0] out_byte
);
    import bae_pkg::*;

    logic [CODE_W-1:0] low_reg,  low_next;
    logic [CODE_W-1:0] high_reg, high_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROB_W-1:0] prob_reg;
    logic              cmd_reg;
    logic              bit_reg;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [CODE_W-1:0] span;
    logic [CODE_W-1:0] mid;
    logic              top_equal;
    logic              next_top_equal;

    assign span           = high_reg - low_reg;
    assign mid            = low_reg + prod_reg[PROD_W-1:PROB_W];
    assign top_equal      = low_reg[CODE_W-1 -: BYTE_W] == high_reg[CODE_W-1 -: BYTE_W];
    assign next_top_equal = low_reg[CODE_W-BYTE_W-1 -: BYTE_W]
                            == high_reg[CODE_W-BYTE_W-1 -: BYTE_W];

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        cnt_next  = cnt_reg;
        if (cmd.load) begin
            cnt_next = '0;
        end
        if (cmd.update) begin
            if (bit_reg) begin
                low_next = mid + CODE_W'(1);
            end else begin
                high_next = mid;
            end
        end
        if (cmd.shift) begin
            // a flush shifts four times, leaving low zero and high all ones
            low_next  = {low_reg[CODE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            high_next = {high_reg[CODE_W-BYTE_W-1:0], BYTE_FILL};
            cnt_next  = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= ALL_ONES;
            cnt_reg  <= '0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= in_command;
            bit_reg  <= in_bit_value;
            prob_reg <= in_prob;
        end
        if (cmd.multiply) begin
            prod_reg <= PROD_W'(span) * PROD_W'(prob_reg);
        end
    end

    always_comb begin
        status.is_flush = cmd_reg == CMD_FLUSH;
        if (status.is_flush) begin
            status.emit_avail = cnt_reg < CNT_MAX;
            status.last       = cnt_reg == CNT_FINAL;
        end else begin
            status.emit_avail = top_equal && (cnt_reg < CNT_MAX);
            status.last       = (cnt_reg == CNT_FINAL) || !next_top_equal;
        end
    end

    assign out_byte = low_reg[CODE_W-1 -: BYTE_W];

endmodule

[design/bae_ctrl.sv]
// Controller state machine of the binary arithmetic encoder.
// Depends on bae_pkg; sequences bae_datapath through dp_cmd_t.
module bae_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  bae_pkg::dp_status_t status,
    output bae_pkg::dp_cmd_t    cmd
);
    import bae_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // hold off input while reset is applied
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // flush skips the split and goes straight to the byte loop
                if (status.is_flush) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.multiply = 1'b1;
                    state_next   = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = status.emit_avail;
                if (!status.emit_avail) begin
                    state_next = ST_IDLE;
                end else if (m_ready) begin
                    cmd.shift = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[verif/tb_binary_arithmetic_encoder.sv]
// Self-checking testbench for the 32-bit carryless binary arithmetic encoder.
// Depends on bae_pkg and binary_arithmetic_encoder; the scoreboard class lives in this file.
// Directed corner cases, then random coded streams, with random idling on both channels.
module tb_binary_arithmetic_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bae_pkg::*;

    localparam int RANDOM_ITEMS = 157;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    // One expected code byte on the result channel
    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last;
    } code_byte_t;

    // Scoreboard: keeps its own copy of the interval bounds, turns every
    // accepted input transaction into the bytes it must produce, and matches
    // result transactions against them in order.
    class code_scoreboard;
        logic [CODE_W-1:0] bound_low;
        logic [CODE_W-1:0] bound_high;
        code_byte_t        pending_bytes[$];
        int                mismatches;

        function new();
            bound_low  = '0;
            bound_high = ALL_ONES;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        // Append one expected byte at the tail of the queue.
        function void add_expected(code_byte_t entry);
            pending_bytes = {pending_bytes, entry};
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        // Advance the bound model by one accepted input transaction.
        function void note_input(logic cmd, logic bit_value, logic [PROB_W-1:0] prob);
            logic [PROD_W-1:0] product;
            logic [CODE_W-1:0] split;
            code_byte_t        entry;
            int                emitted;
            emitted = 0;
            if (cmd == CMD_FLUSH) begin
                for (int i = 0; i < MAX_BYTES; i++) begin
                    entry.code_byte = bound_low[CODE_W-1-BYTE_W*i -: BYTE_W];
                    entry.last      = (i == MAX_BYTES - 1);
                    add_expected(entry);
                end
                bound_low  = '0;
                bound_high = ALL_ONES;
                return;
            end
            product = {{PROB_W{1'b0}}, bound_high - bound_low} * {{CODE_W{1'b0}}, prob};
            split   = bound_low + product[PROD_W-1:PROB_W];
            if (bit_value)
                bound_low = split + 1'b1;
            else
                bound_high = split;
            // Shift out settled top bytes, at most four
            while (emitted < MAX_BYTES
                   && bound_low[CODE_W-1 -: BYTE_W] == bound_high[CODE_W-1 -: BYTE_W]) begin
                entry.code_byte = bound_low[CODE_W-1 -: BYTE_W];
                entry.last      = 1'b0;
                add_expected(entry);
                bound_low  = bound_low << BYTE_W;
                bound_high = {bound_high[CODE_W-BYTE_W-1:0], BYTE_FILL};
                emitted++;
            end
            if (emitted > 0)
                pending_bytes[pending_bytes.size()-1].last = 1'b1;
        endfunction

        task check_result(logic [BYTE_W-1:0] code_byte, logic last);
            code_byte_t want;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last=%0b", code_byte, last));
                return;
            end
            want = pending_bytes.pop_front();
            if (code_byte !== want.code_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", code_byte, want.code_byte));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                          last, want.last, want.code_byte));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_command;
    logic              s_bit_value;
    logic [PROB_W-1:0] s_prob;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last;

    code_scoreboard sb = new();
    int             cycles = 0;
    int             tx_calm = 0;   // remaining transactions sent without gaps
    int             rx_calm = 0;   // remaining results taken without stalls

    binary_arithmetic_encoder dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_bit_value(s_bit_value),
        .s_prob     (s_prob),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog: end the run with an error report when the cycle counter reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_binary_arithmetic_encoder: errors");
            $finish;
        end
    end

    // Draw an idle count of 0..14, with occasional stretches of no idling at all.
    function automatic int draw_idle(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Present one input transaction, starting and ending at a falling edge.
    // Drop valid only when a gap is drawn, so back-to-back transactions keep
    // valid high without a second assignment in the same step.
    task automatic send_item(logic cmd, logic bit_value, logic [PROB_W-1:0] prob);
        int gap;
        gap = draw_idle(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_bit_value <= bit_value;
        s_prob      <= prob;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(cmd, bit_value, prob);
        @(negedge aclk);
    endtask

    task automatic send_encode(logic bit_value, logic [PROB_W-1:0] prob);
        send_item(CMD_ENCODE, bit_value, prob);
    endtask

    // Flush ignores bit_value and prob: keep them random to prove it.
    task automatic send_flush();
        send_item(CMD_FLUSH, 1'($urandom), PROB_W'($urandom));
    endtask

    // Pick a split scale: extremes half of the time, otherwise uniform.
    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PROB_W'(1);
            2:       return {PROB_W{1'b1}};
            3:       return {PROB_W{1'b1}} - 1'b1;
            default: return PROB_W'($urandom);
        endcase
    endfunction

    // Result side: stall at random, then take one byte per handshake.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin : take_byte
            int stall;
            stall = draw_idle(rx_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_result(m_out_byte, m_last);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int               sent;
        int               stream_len;
        logic [PROB_W-1:0] prob;
        logic              bit_value;
        s_valid     = 1'b0;
        s_command   = CMD_ENCODE;
        s_bit_value = 1'b0;
        s_prob      = '0;
        aresetn     = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Flush straight out of reset: four zero bytes.
        send_flush();
        // Even split, upper half: no settled byte yet.
        send_encode(1'b1, 12'd2048);
        // Zero scale with a zero collapses the interval: all four bytes of low.
        send_encode(1'b0, '0);
        // Zero scale with a one moves low up by one only.
        send_encode(1'b1, '0);
        // Largest scale, both bits.
        send_encode(1'b1, {PROB_W{1'b1}});
        send_encode(1'b0, {PROB_W{1'b1}});
        // Smallest nonzero scale, both bits: a zero shrinks the interval to a tiny one.
        send_encode(1'b0, PROB_W'(1));
        send_encode(1'b1, PROB_W'(1));
        // Flush in the middle of a stream, twice back to back.
        send_flush();
        send_flush();
        // Likely zeros under a high scale shrink the interval slowly.
        repeat (8) send_encode(1'b0, {PROB_W{1'b1}});
        send_encode(1'b1, 12'd2048);
        send_encode(1'b0, 12'd1);
        send_encode(1'b1, 12'd4094);
        send_flush();

        // Random coded streams: bits mostly follow the scale, as a real
        // model would drive them; some streams end with a flush, some not.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            stream_len = $urandom_range(3, 30);
            for (int i = 0; i < stream_len && sent < RANDOM_ITEMS; i++) begin
                prob = pick_prob();
                if ($urandom_range(0, 6) == 0)
                    bit_value = 1'($urandom);
                else
                    bit_value = (PROB_W'($urandom) >= prob);
                send_encode(bit_value, prob);
                sent++;
            end
            if (sent < RANDOM_ITEMS && $urandom_range(0, 3) != 0) begin
                send_flush();
                sent++;
            end
        end
        send_flush();
        s_valid <= 1'b0;

        // Hold until every expected byte has arrived, then watch for strays.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb_binary_arithmetic_encoder: clean");
        else
            $display("tb_binary_arithmetic_encoder: errors");
        $finish;
    end

endmodule

[filelist.f]
design/bae_pkg.sv
design/bae_datapath.sv
design/bae_ctrl.sv
design/binary_arithmetic_encoder.sv
verif/tb_binary_arithmetic_encoder.sv
